// File: hw/rtl/buffer_cache_getblk_macros.svh
// Assertion macros for the buffer cache lookup block.
// Used by the checker module; no other dependencies.
`ifndef BUFFER_CACHE_GETBLK_MACROS_SVH
`define BUFFER_CACHE_GETBLK_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BCG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("buffer cache check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BCG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("buffer cache check failed");

`endif

// File: hw/rtl/bcg_pkg.sv
// Shared types and codes for the buffer cache lookup block.
// No dependencies; used by the controller, datapath, top level and checker.
package bcg_pkg;

  localparam int IDX_PORT_W = 3;

  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_LOAD    = 1'b1;

  typedef enum logic [2:0] {
    STS_HIT      = 3'd0,
    STS_HIT_WAIT = 3'd1,
    STS_REASSIGN = 3'd2,
    STS_NO_FREE  = 3'd3,
    STS_DELAYED  = 3'd4,
    STS_LOADED   = 3'd5
  } status_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic do_load;
    logic do_hit;
    logic do_empty;
    logic do_flush;
    logic do_reassign;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_load;
    logic hit;
    logic q_empty;
    logic head_delayed;
    logic slot_free;
  } stat_t;

endpackage

// File: hw/rtl/bcg_ctrl.sv
// Sequencer for the buffer cache lookup block.
// Depends on bcg_pkg; drives the datapath through cmd_t and reads stat_t.
module bcg_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  bcg_pkg::stat_t stat_i,
  output bcg_pkg::cmd_t  cmd_o
);

  bcg_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bcg_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      bcg_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = bcg_pkg::ST_EXEC;
        end
      end
      bcg_pkg::ST_EXEC: begin
        // hold until the result register can take a result
        if (stat_i.slot_free) begin
          if (stat_i.is_load) begin
            cmd_o.do_load = 1'b1;
            state_d       = bcg_pkg::ST_IDLE;
          end else if (stat_i.hit) begin
            cmd_o.do_hit = 1'b1;
            state_d      = bcg_pkg::ST_IDLE;
          end else if (stat_i.q_empty) begin
            cmd_o.do_empty = 1'b1;
            state_d        = bcg_pkg::ST_IDLE;
          end else if (stat_i.head_delayed) begin
            cmd_o.do_flush = 1'b1;
          end else begin
            cmd_o.do_reassign = 1'b1;
            state_d           = bcg_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = bcg_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/bcg_dp.sv
// Datapath of the buffer cache lookup block: pool entries, free queue
// order, request register and result register. Depends on bcg_pkg.
module bcg_dp #(
  parameter int POOL_SIZE = 8,
  parameter int TAG_BITS  = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  bcg_pkg::cmd_t                      cmd_i,
  output bcg_pkg::stat_t                     stat_o,
  input  logic                               opcode_i,
  input  logic [bcg_pkg::IDX_PORT_W-1:0]     entry_index_i,
  input  logic [TAG_BITS-1:0]                block_number_i,
  input  logic                               load_busy_i,
  input  logic                               load_delayed_i,
  input  logic                               load_on_free_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [2:0]                         status_o,
  output logic [bcg_pkg::IDX_PORT_W-1:0]     out_index_o,
  output logic [TAG_BITS-1:0]                out_block_o,
  output logic [TAG_BITS-1:0]                prior_block_o,
  output logic                               last_o
);

  localparam int IDX_W   = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int CNT_W   = $clog2(POOL_SIZE + 1);
  localparam int OutIdxW = bcg_pkg::IDX_PORT_W;

  // Fold a raw entry number into the pool range.
  function automatic logic [IDX_W-1:0] wrap_index(input logic [OutIdxW-1:0] raw);
    logic [OutIdxW:0] v;
    v = {1'b0, raw};
    for (int k = 0; k < 4; k++) begin
      if (int'(v) >= POOL_SIZE) v = v - (OutIdxW + 1)'(POOL_SIZE);
    end
    return IDX_W'(v);
  endfunction

  // Request register
  logic                req_op_q;
  logic [IDX_W-1:0]    req_idx_q;
  logic [TAG_BITS-1:0] req_blk_q;
  logic                req_busy_q, req_delayed_q, req_on_free_q;

  // Pool entries; rank_q is the position in the free queue
  logic [TAG_BITS-1:0]  tag_q   [POOL_SIZE];
  logic [TAG_BITS-1:0]  tag_d   [POOL_SIZE];
  logic [IDX_W-1:0]     rank_q  [POOL_SIZE];
  logic [IDX_W-1:0]     rank_d  [POOL_SIZE];
  logic [POOL_SIZE-1:0] valid_q, valid_d, busy_q, busy_d;
  logic [POOL_SIZE-1:0] delayed_q, delayed_d, onq_q, onq_d;
  logic [CNT_W-1:0]     count_q, count_d, count_rm;

  logic             hit, head_found;
  logic [IDX_W-1:0] hit_idx, head_idx, sel_idx, rm_rank;
  logic             rm, emit, slot_free;

  // Result register
  logic                out_valid_q;
  bcg_pkg::status_e    status_q, status_d;
  logic [IDX_W-1:0]    oidx_q, oidx_d;
  logic [TAG_BITS-1:0] oblk_q, oblk_d, prior_q, prior_d;
  logic                last_q, last_d;

  // Associative tag match and free queue head; lowest entry wins
  always_comb begin
    hit        = 1'b0;
    hit_idx    = '0;
    head_found = 1'b0;
    head_idx   = '0;
    for (int i = POOL_SIZE - 1; i >= 0; i--) begin
      if (valid_q[i] && tag_q[i] == req_blk_q) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (onq_q[i] && rank_q[i] == '0) begin
        head_found = 1'b1;
        head_idx   = IDX_W'(i);
      end
    end
  end

  assign sel_idx   = (req_op_q == bcg_pkg::OP_LOAD) ? req_idx_q :
                     (hit ? hit_idx : head_idx);
  assign slot_free = !out_valid_q || !out_stall_i;
  assign emit      = cmd_i.do_load | cmd_i.do_hit | cmd_i.do_empty |
                     cmd_i.do_flush | cmd_i.do_reassign;

  assign stat_o.is_load      = (req_op_q == bcg_pkg::OP_LOAD);
  assign stat_o.hit          = hit;
  assign stat_o.q_empty      = (count_q == '0) || !head_found;
  assign stat_o.head_delayed = delayed_q[head_idx];
  assign stat_o.slot_free    = slot_free;

  // Pool and free queue update
  always_comb begin
    tag_d     = tag_q;
    rank_d    = rank_q;
    valid_d   = valid_q;
    busy_d    = busy_q;
    delayed_d = delayed_q;
    onq_d     = onq_q;
    rm        = (cmd_i.do_load | cmd_i.do_hit | cmd_i.do_flush | cmd_i.do_reassign) &&
                onq_q[sel_idx];
    rm_rank   = rank_q[sel_idx];
    count_rm  = count_q - CNT_W'(rm);
    count_d   = count_q;

    // close the gap left by the removed entry
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (rm && onq_q[i] && rank_q[i] > rm_rank) rank_d[i] = rank_q[i] - IDX_W'(1);
    end
    if (rm) begin
      onq_d[sel_idx] = 1'b0;
      count_d        = count_rm;
    end

    if (cmd_i.do_load) begin
      tag_d[sel_idx]     = req_blk_q;
      valid_d[sel_idx]   = 1'b1;
      busy_d[sel_idx]    = req_busy_q;
      delayed_d[sel_idx] = req_delayed_q;
      if (req_on_free_q && !req_busy_q) begin
        onq_d[sel_idx]  = 1'b1;
        rank_d[sel_idx] = IDX_W'(count_rm);
        count_d         = count_rm + CNT_W'(1);
      end
    end
    if (cmd_i.do_hit) busy_d[sel_idx] = 1'b1;
    if (cmd_i.do_flush) begin
      // clean the head and requeue it at the tail
      delayed_d[sel_idx] = 1'b0;
      onq_d[sel_idx]     = 1'b1;
      rank_d[sel_idx]    = IDX_W'(count_q - CNT_W'(1));
      count_d            = count_q;
    end
    if (cmd_i.do_reassign) begin
      tag_d[sel_idx]   = req_blk_q;
      valid_d[sel_idx] = 1'b1;
      busy_d[sel_idx]  = 1'b1;
    end
  end

  // Result selection
  always_comb begin
    status_d = bcg_pkg::STS_NO_FREE;
    oidx_d   = '0;
    oblk_d   = '0;
    prior_d  = '0;
    last_d   = 1'b1;
    if (cmd_i.do_load) begin
      status_d = bcg_pkg::STS_LOADED;
      oidx_d   = sel_idx;
      oblk_d   = req_blk_q;
    end else if (cmd_i.do_hit) begin
      status_d = busy_q[sel_idx] ? bcg_pkg::STS_HIT_WAIT : bcg_pkg::STS_HIT;
      oidx_d   = sel_idx;
      oblk_d   = req_blk_q;
    end else if (cmd_i.do_flush) begin
      status_d = bcg_pkg::STS_DELAYED;
      oidx_d   = sel_idx;
      oblk_d   = tag_q[sel_idx];
      last_d   = 1'b0;
    end else if (cmd_i.do_reassign) begin
      status_d = bcg_pkg::STS_REASSIGN;
      oidx_d   = sel_idx;
      oblk_d   = req_blk_q;
      prior_d  = tag_q[sel_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      busy_q      <= '0;
      delayed_q   <= '0;
      onq_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < POOL_SIZE; i++) rank_q[i] <= '0;
    end else begin
      valid_q   <= valid_d;
      busy_q    <= busy_d;
      delayed_q <= delayed_d;
      onq_q     <= onq_d;
      count_q   <= count_d;
      rank_q    <= rank_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q <= tag_d;
    if (cmd_i.capture) begin
      req_op_q      <= opcode_i;
      req_idx_q     <= wrap_index(entry_index_i);
      req_blk_q     <= block_number_i;
      req_busy_q    <= load_busy_i;
      req_delayed_q <= load_delayed_i;
      req_on_free_q <= load_on_free_i;
    end
    if (emit) begin
      status_q <= status_d;
      oidx_q   <= oidx_d;
      oblk_q   <= oblk_d;
      prior_q  <= prior_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign out_index_o   = OutIdxW'(oidx_q);
  assign out_block_o   = oblk_q;
  assign prior_block_o = prior_q;
  assign last_o        = last_q;

endmodule

// File: hw/rtl/buffer_cache_getblk.sv
// Buffer cache block lookup: top level joining sequencer and datapath.
// Depends on bcg_pkg, bcg_ctrl and bcg_dp.
//
// Usage:
//   The request channel (in_valid_i / in_stall_o) carries either a load
//   request (opcode 1), which sets up one pool entry, or a block request
//   (opcode 0), which looks up a block by tag and, on a miss, takes the
//   free queue head. The result channel (out_valid_o / out_stall_i) returns
//   one result per load, hit, clean miss or empty free queue, preceded by
//   one delayed-write result (last_o low) for each dirty head written back
//   on the way. A request is held in the request register, and each of its
//   results is registered in the result register. The sequencer takes one
//   request at a time, holding in_stall_o high until it is done, and retires
//   one free queue head or lookup per cycle while the result register is
//   free, so a stalled receiver holds back the next head or lookup.
//   Reset clears all entry flags and empties the free queue; there is no
//   clearing pass, so requests are taken from the first cycle after reset.
//   While the receiver stalls, the current result holds in the output
//   register; the next request is still accepted, and its processing
//   waits until the output register frees up.
module buffer_cache_getblk #(
  parameter int POOL_SIZE = 8,
  parameter int TAG_BITS  = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           opcode_i,
  input  logic [bcg_pkg::IDX_PORT_W-1:0] entry_index_i,
  input  logic [TAG_BITS-1:0]            block_number_i,
  input  logic                           load_busy_i,
  input  logic                           load_delayed_i,
  input  logic                           load_on_free_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [2:0]                     status_o,
  output logic [bcg_pkg::IDX_PORT_W-1:0] out_index_o,
  output logic [TAG_BITS-1:0]            out_block_o,
  output logic [TAG_BITS-1:0]            prior_block_o,
  output logic                           last_o
);

  // command and status between sequencer and datapath
  bcg_pkg::cmd_t  cmd;
  bcg_pkg::stat_t stat;

  bcg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bcg_dp #(
    .POOL_SIZE (POOL_SIZE),
    .TAG_BITS  (TAG_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .opcode_i       (opcode_i),
    .entry_index_i  (entry_index_i),
    .block_number_i (block_number_i),
    .load_busy_i    (load_busy_i),
    .load_delayed_i (load_delayed_i),
    .load_on_free_i (load_on_free_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .out_index_o    (out_index_o),
    .out_block_o    (out_block_o),
    .prior_block_o  (prior_block_o),
    .last_o         (last_o)
  );

endmodule

// File: hw/rtl/bcg_checker.sv
// Port-level checks for the buffer cache lookup block, bound to the top.
// Depends on bcg_pkg and buffer_cache_getblk_macros.svh.
`include "buffer_cache_getblk_macros.svh"

module bcg_checker #(
  parameter int POOL_SIZE = 8,
  parameter int TAG_BITS  = 32
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           opcode_i,
  input logic [bcg_pkg::IDX_PORT_W-1:0] entry_index_i,
  input logic [TAG_BITS-1:0]            block_number_i,
  input logic                           load_busy_i,
  input logic                           load_delayed_i,
  input logic                           load_on_free_i,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [2:0]                     status_o,
  input logic [bcg_pkg::IDX_PORT_W-1:0] out_index_o,
  input logic [TAG_BITS-1:0]            out_block_o,
  input logic [TAG_BITS-1:0]            prior_block_o,
  input logic                           last_o
);

  localparam int PoolSize = POOL_SIZE;

  // hold a stalled result
  `BCG_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(status_o) && $stable(out_block_o) && $stable(last_o))

  // only delayed-write results leave a request open
  `BCG_ASSERT_NOW(a_last_flag, out_valid_o, last_o == (status_o != bcg_pkg::STS_DELAYED))

  // a failed lookup reports all zero fields
  `BCG_ASSERT_NOW(a_no_free, out_valid_o && status_o == bcg_pkg::STS_NO_FREE, out_index_o == '0 && out_block_o == '0 && prior_block_o == '0)

  // prior tag shows only on a reassignment
  `BCG_ASSERT_NOW(a_prior_zero, out_valid_o && status_o != bcg_pkg::STS_REASSIGN && PoolSize > 0, prior_block_o == '0)

  // one request at a time inside the block
  `BCG_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)

endmodule

bind buffer_cache_getblk bcg_checker #(
  .POOL_SIZE (POOL_SIZE),
  .TAG_BITS  (TAG_BITS)
) u_bcg_checker (.*);
